// ===== rtl/hbp_pkg.sv =====
// Shared types and constants for the Huffman table bit packer.
// Used by hbp_code_table and huffman_table_bit_packer_core; no dependencies.
package hbp_pkg;

   localparam int SYM_W                   = 8;
   localparam int CODE_W                  = 8;
   localparam int LEN_W                   = 4;
   localparam int VALID_W                 = 4;
   localparam int DEF_MAX_CODE_LENGTH     = 8;
   localparam int DEF_ALPHABET_SIZE       = 256;
   localparam int FIFO_DEPTH              = 4;
   localparam int FIFO_PTR_W              = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W              = FIFO_PTR_W + 1;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_ENCODE = 1'b1
   } hbp_op_type;

   typedef struct packed {
      hbp_op_type         operation;
      logic [SYM_W-1:0]   symbol;
      logic [CODE_W-1:0]  code_bits;
      logic [LEN_W-1:0]   code_length;
      logic               last_symbol;
   } hbp_req_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic [VALID_W-1:0] valid_bits;
      logic               final_byte;
   } hbp_rsp_type;

   // One table entry as seen outside the table: code right aligned.
   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [LEN_W-1:0]   len;
   } hbp_entry_type;

   // Table write request, raw values from a load item.
   typedef struct packed {
      logic               en;
      logic [SYM_W-1:0]   addr;
      hbp_entry_type      entry;
   } hbp_tbl_wr_type;

endpackage

// ===== rtl/hbp_code_table.sv =====
// Codeword table: one memory word per symbol plus a valid bit per entry.
// Depends on hbp_pkg. Read data is registered; an entry never loaded reads as length zero.
module hbp_code_table
   import hbp_pkg::*;
#(
   parameter int ALPHABET_SIZE   = DEF_ALPHABET_SIZE,
   parameter int MAX_CODE_LENGTH = DEF_MAX_CODE_LENGTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  hbp_tbl_wr_type                        wr,
   input  logic                                  rd_en,
   input  logic [$clog2(ALPHABET_SIZE)-1:0]      rd_addr,
   output hbp_entry_type                         rd_entry
);

   localparam int IDX_W   = $clog2(ALPHABET_SIZE);
   localparam int EFF_LEN = (MAX_CODE_LENGTH < CODE_W) ? MAX_CODE_LENGTH : CODE_W;
   localparam int ENTRY_W = EFF_LEN + LEN_W;

   logic [ENTRY_W-1:0]       mem_ff [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] vld_ff;
   logic [ENTRY_W-1:0]       rd_word_ff;
   logic                     rd_vld_ff;

   logic [LEN_W-1:0]         len_sat;
   logic [CODE_W-1:0]        code_mask;
   logic [CODE_W-1:0]        code_masked;
   logic [IDX_W-1:0]         wr_idx;

   // Lengths above the limit saturate; code bits above the length are dropped.
   always_comb begin
      len_sat     = (wr.entry.len > LEN_W'(EFF_LEN)) ? LEN_W'(EFF_LEN) : wr.entry.len;
      code_mask   = CODE_W'(((CODE_W+1)'(1) << len_sat) - (CODE_W+1)'(1));
      code_masked = wr.entry.code & code_mask;
      wr_idx      = wr.addr[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_idx] <= {code_masked[EFF_LEN-1:0], len_sat};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem_ff[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   // A word never loaded holds stale or unknown bits, so its code is forced to zero too.
   always_comb begin
      rd_entry.code = rd_vld_ff ? CODE_W'(rd_word_ff[ENTRY_W-1:LEN_W]) : '0;
      rd_entry.len  = rd_vld_ff ? rd_word_ff[LEN_W-1:0] : '0;
   end

endmodule

// ===== rtl/huffman_table_bit_packer_core.sv =====
// Huffman table bit packer: code table lookup, bit merge and output queue.
// Depends on hbp_pkg and hbp_code_table.
//
// Usage: items enter on req_valid/req_ready with an hbp_req_type payload.
// A load item (operation OP_LOAD) writes one table entry and gives no result;
// an encode item appends the symbol's codeword to the bit accumulator.
// Each completed byte leaves on rsp_valid/rsp_ready as an hbp_rsp_type item;
// an encode item marked last_symbol also flushes a partial byte, zero padded,
// with valid_bits telling how many leading bits count.
// A result is registered by the table read, then by the output queue, before it
// is offered. A load is visible to an encode accepted in the very next cycle.
// Throughput: one item per cycle. The table read is registered, and the merge
// stage writes up to two results per item into a four-entry output queue; the
// merge stage waits only when fewer than two queue entries are free.
// A stalled receiver fills the queue, then req_ready drops.
// Reset: synchronous; clears the accumulator, the queue and every table valid
// bit, so all symbols read as length zero afterwards.
module huffman_table_bit_packer_core
   import hbp_pkg::*;
#(
   parameter int MAX_CODE_LENGTH = DEF_MAX_CODE_LENGTH,
   parameter int ALPHABET_SIZE   = DEF_ALPHABET_SIZE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  hbp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hbp_rsp_type rsp_data
);

   localparam int IDX_W   = $clog2(ALPHABET_SIZE);
   localparam int LIM_W   = SYM_W + 1;
   localparam int ACC_W   = 15;
   localparam int PEND_W  = 7;
   localparam int PCNT_W  = 3;

   // Input stage
   logic                  req_fire;
   logic                  sym_ok;
   hbp_tbl_wr_type        tbl_wr;
   logic                  tbl_rd_en;
   hbp_entry_type         tbl_entry;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_last_ff;
   logic                  s1_sym_ok_ff;
   logic                  s1_adv;

   // Merge stage
   logic [PEND_W-1:0]     pend_bits_ff, pend_bits_in;
   logic [PCNT_W-1:0]     pend_cnt_ff, pend_cnt_in;
   logic [LEN_W-1:0]      len;
   logic [ACC_W-1:0]      acc;
   logic [LEN_W-1:0]      total;
   logic [PCNT_W-1:0]     rem;
   logic [PEND_W-1:0]     npend;
   logic [PCNT_W-1:0]     ncnt;
   logic                  has_full;
   logic                  has_flush;
   hbp_rsp_type           full_rsp;
   hbp_rsp_type           flush_rsp;
   hbp_rsp_type           slot0;
   logic [1:0]            push_n;

   // Output queue
   hbp_rsp_type           fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  pop;

   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;
   assign sym_ok    = ({1'b0, req_data.symbol} < LIM_W'(ALPHABET_SIZE));

   always_comb begin
      tbl_wr.en         = req_fire && (req_data.operation == OP_LOAD) && sym_ok;
      tbl_wr.addr       = req_data.symbol;
      tbl_wr.entry.code = req_data.code_bits;
      tbl_wr.entry.len  = req_data.code_length;
   end

   assign tbl_rd_en   = req_fire && (req_data.operation == OP_ENCODE);
   assign s1_valid_in = tbl_rd_en ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   hbp_code_table #(
      .ALPHABET_SIZE   (ALPHABET_SIZE),
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd_en    (tbl_rd_en),
      .rd_addr  (req_data.symbol[IDX_W-1:0]),
      .rd_entry (tbl_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_rd_en) begin
         s1_last_ff   <= req_data.last_symbol;
         s1_sym_ok_ff <= sym_ok;
      end
   end

   // The merge stage advances only when the queue can take two results.
   assign s1_adv = s1_valid_ff && (cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));

   always_comb begin
      len   = s1_sym_ok_ff ? tbl_entry.len : '0;
      acc   = (ACC_W'(pend_bits_ff) << len) | ACC_W'(tbl_entry.code & {CODE_W{s1_sym_ok_ff}});
      total = LEN_W'(pend_cnt_ff) + len;
      rem   = PCNT_W'(total - LEN_W'(8));

      has_full            = (total >= LEN_W'(8));
      full_rsp.out_byte   = 8'(acc >> rem);
      full_rsp.valid_bits = VALID_W'(8);
      full_rsp.final_byte = s1_last_ff && (rem == '0);

      if (has_full) begin
         npend = PEND_W'(acc & ((ACC_W'(1) << rem) - ACC_W'(1)));
         ncnt  = rem;
      end else begin
         npend = acc[PEND_W-1:0];
         ncnt  = total[PCNT_W-1:0];
      end

      has_flush            = s1_last_ff && (ncnt != '0);
      flush_rsp.out_byte   = 8'(ACC_W'(npend) << (LEN_W'(8) - LEN_W'(ncnt)));
      flush_rsp.valid_bits = VALID_W'(ncnt);
      flush_rsp.final_byte = 1'b1;

      slot0  = has_full ? full_rsp : flush_rsp;
      push_n = s1_adv ? (2'(has_full) + 2'(has_flush)) : 2'd0;

      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      if (s1_adv) begin
         pend_bits_in = s1_last_ff ? '0 : npend;
         pend_cnt_in  = s1_last_ff ? '0 : ncnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      cnt_in    = cnt_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // When both results are present the full byte goes first, the flush second.
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= slot0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= flush_rsp;
      end
   end

`ifndef SYNTHESIS
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("output queue count exceeds its depth");

   a_last_clears : assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (pend_cnt_ff == '0 && pend_bits_ff == '0))
      else $error("accumulator not cleared after last symbol");

   a_partial_is_final : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.valid_bits != VALID_W'(8)) |-> rsp_data.final_byte)
      else $error("partial byte not marked final");

   a_valid_bits_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.valid_bits != '0 && rsp_data.valid_bits <= VALID_W'(8)))
      else $error("valid_bits out of range");
`endif

endmodule
